>>> src/assert_macros.svh
// Assertion macros shared by the semaphore unit modules.
// Needs a clock named clk and an active-low reset named rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every clock edge outside reset.
`define CSM_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// The expression must never be true outside reset.
`define CSM_NEVER(lbl, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

>>> src/csm_pkg.sv
// Shared types, codes and constants of the counting semaphore unit.
// No dependencies; csm_ctrl, csm_dp, the top module and the testbench import it.
package csm_pkg;

    localparam int QUEUE_DEPTH       = 16;
    localparam int DEF_NUM_RESOURCES = 8;
    localparam int DEF_MAX_PROCESSES = 16;

    localparam logic signed [8:0] COUNT_MAX = 9'sd255;
    localparam logic signed [8:0] COUNT_MIN = -9'sd256;
    localparam logic [3:0]        HELD_MAX  = 4'd15;
    localparam logic [3:0]        WAKE_REPORT_MAX = 4'd15;

    localparam logic [1:0] CMD_WAIT    = 2'd0;
    localparam logic [1:0] CMD_SIGNAL  = 2'd1;
    localparam logic [1:0] CMD_RELEASE = 2'd2;
    localparam logic [1:0] CMD_UNUSED  = 2'd3;

    localparam logic [2:0] EV_GRANTED      = 3'd0;
    localparam logic [2:0] EV_BLOCKED      = 3'd1;
    localparam logic [2:0] EV_INVALID      = 3'd2;
    localparam logic [2:0] EV_WOKEN        = 3'd3;
    localparam logic [2:0] EV_SIGNAL_DONE  = 3'd4;
    localparam logic [2:0] EV_RELEASE_DONE = 3'd5;

    localparam logic CFG_RESOURCE_COUNT    = 1'b0;
    localparam logic CFG_INITIAL_INSTANCES = 1'b1;

    localparam logic [3:0] OP_NOP     = 4'd0;
    localparam logic [3:0] OP_LATCH   = 4'd1;
    localparam logic [3:0] OP_LOOKUP  = 4'd2;
    localparam logic [3:0] OP_WAIT    = 4'd3;
    localparam logic [3:0] OP_SIG     = 4'd4;
    localparam logic [3:0] OP_RQ      = 4'd5;
    localparam logic [3:0] OP_RQ_CHK  = 4'd6;
    localparam logic [3:0] OP_RH_RD   = 4'd7;
    localparam logic [3:0] OP_RH_LOAD = 4'd8;
    localparam logic [3:0] OP_RW      = 4'd9;
    localparam logic [3:0] OP_POP     = 4'd10;
    localparam logic [3:0] OP_RD_HW   = 4'd11;
    localparam logic [3:0] OP_WAKE    = 4'd12;

    typedef struct packed {
        logic [1:0] cmd;
        logic [3:0] resource_index;
        logic [3:0] process_id;
    } req_t;

    typedef struct packed {
        logic [2:0] event_res;
        logic [3:0] event_process;
        logic [3:0] event_resource;
        logic       last;
    } rsp_t;

    typedef struct packed {
        logic [3:0] op;
        logic       ev_valid;
        logic [2:0] ev_code;
        logic       ev_last;
    } dp_cmd_t;

    typedef struct packed {
        logic [1:0] cmd;
        logic       pid_bad;
        logic       res_bad;
        logic       wait_neg;
        logic       q_full;
        logic       len_nz;
        logic       i_lt_len;
        logic       r_last;
        logic       h_nz;
        logic       woke_full;
    } dp_stat_t;

endpackage

>>> src/csm_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module csm_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

>>> src/csm_ctrl.sv
// Controller state machine of the semaphore unit: sequences datapath operations.
// Depends on csm_pkg and assert_macros.svh.
`include "assert_macros.svh"

module csm_ctrl import csm_pkg::*; (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    output logic     busy,
    input  dp_stat_t stat,
    output dp_cmd_t  ctl
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_CHECK = 4'd1;
    localparam logic [3:0] S_INV   = 4'd2;
    localparam logic [3:0] S_WAIT  = 4'd3;
    localparam logic [3:0] S_SIG   = 4'd4;
    localparam logic [3:0] S_SDONE = 4'd5;
    localparam logic [3:0] S_RQ    = 4'd6;
    localparam logic [3:0] S_RQC   = 4'd7;
    localparam logic [3:0] S_RH    = 4'd8;
    localparam logic [3:0] S_RHL   = 4'd9;
    localparam logic [3:0] S_RW    = 4'd10;
    localparam logic [3:0] S_POP   = 4'd11;
    localparam logic [3:0] S_RDW   = 4'd12;
    localparam logic [3:0] S_WAKE  = 4'd13;
    localparam logic [3:0] S_RDONE = 4'd14;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        ctl.op       = OP_NOP;
        ctl.ev_valid = 1'b0;
        ctl.ev_code  = EV_GRANTED;
        ctl.ev_last  = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    ctl.op     = OP_LATCH;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                ctl.op = OP_LOOKUP;
                if (stat.cmd == CMD_UNUSED)
                begin
                    state_next = S_IDLE;
                end
                else if (stat.pid_bad || (stat.cmd != CMD_RELEASE && stat.res_bad))
                begin
                    state_next = S_INV;
                end
                else if (stat.cmd == CMD_WAIT)
                begin
                    state_next = S_WAIT;
                end
                else if (stat.cmd == CMD_SIGNAL)
                begin
                    state_next = S_SIG;
                end
                else
                begin
                    state_next = S_RQ;
                end
            end
            S_INV:
            begin
                ctl.ev_valid = 1'b1;
                ctl.ev_code  = EV_INVALID;
                ctl.ev_last  = 1'b1;
                state_next   = S_IDLE;
            end
            S_WAIT:
            begin
                ctl.op       = OP_WAIT;
                ctl.ev_valid = 1'b1;
                ctl.ev_last  = 1'b1;
                if (stat.wait_neg && stat.q_full)
                begin
                    ctl.ev_code = EV_INVALID;
                end
                else if (stat.wait_neg)
                begin
                    ctl.ev_code = EV_BLOCKED;
                end
                else
                begin
                    ctl.ev_code = EV_GRANTED;
                end
                state_next = S_IDLE;
            end
            S_SIG:
            begin
                ctl.op     = OP_SIG;
                state_next = stat.len_nz ? S_RDW : S_SDONE;
            end
            S_SDONE:
            begin
                ctl.ev_valid = 1'b1;
                ctl.ev_code  = EV_SIGNAL_DONE;
                ctl.ev_last  = 1'b1;
                state_next   = S_IDLE;
            end
            S_RQ:
            begin
                ctl.op = OP_RQ;
                if (stat.i_lt_len)
                begin
                    state_next = S_RQC;
                end
                else if (stat.r_last)
                begin
                    state_next = S_RH;
                end
            end
            S_RQC:
            begin
                ctl.op     = OP_RQ_CHK;
                state_next = S_RQ;
            end
            S_RH:
            begin
                ctl.op     = OP_RH_RD;
                state_next = S_RHL;
            end
            S_RHL:
            begin
                ctl.op     = OP_RH_LOAD;
                state_next = S_RW;
            end
            S_RW:
            begin
                ctl.op = OP_RW;
                if (stat.h_nz)
                begin
                    state_next = stat.len_nz ? S_POP : S_RW;
                end
                else
                begin
                    state_next = stat.r_last ? S_RDONE : S_RH;
                end
            end
            S_POP:
            begin
                ctl.op     = OP_POP;
                state_next = S_RDW;
            end
            S_RDW:
            begin
                ctl.op     = OP_RD_HW;
                state_next = S_WAKE;
            end
            S_WAKE:
            begin
                ctl.op       = OP_WAKE;
                ctl.ev_valid = !stat.woke_full;
                ctl.ev_code  = EV_WOKEN;
                state_next   = (stat.cmd == CMD_SIGNAL) ? S_SDONE : S_RW;
            end
            S_RDONE:
            begin
                ctl.ev_valid = 1'b1;
                ctl.ev_code  = EV_RELEASE_DONE;
                ctl.ev_last  = 1'b1;
                state_next   = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != S_IDLE);

    `CSM_NEVER(a_idle_no_event, (state_reg == S_IDLE) && ctl.ev_valid, "event while idle")
    `CSM_ASSERT(a_start_to_check, (start && !busy) |=> (state_reg == S_CHECK), "no check")
    `CSM_NEVER(a_last_needs_event, ctl.ev_last && !ctl.ev_valid, "last without event")

endmodule

>>> src/csm_dp.sv
// Datapath of the semaphore unit: counts, queue pointers, holdings and result register.
// Depends on csm_pkg, csm_ram and assert_macros.svh.
`include "assert_macros.svh"

module csm_dp import csm_pkg::*; #(
    parameter int NUM_RESOURCES = DEF_NUM_RESOURCES,
    parameter int MAX_PROCESSES = DEF_MAX_PROCESSES
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    input  logic        cfg_index,
    input  logic [63:0] cfg_data,
    input  req_t        request,
    input  dp_cmd_t     ctl,
    output dp_stat_t    stat,
    output logic        result_valid,
    output rsp_t        result
);

    localparam int RW    = (NUM_RESOURCES > 1) ? $clog2(NUM_RESOURCES) : 1;
    localparam int DEPTH = NUM_RESOURCES * QUEUE_DEPTH;
    localparam int AW    = $clog2(DEPTH);

    function automatic logic [AW-1:0] mk_addr(input logic [RW-1:0] r, input logic [3:0] s);
        return AW'({r, s});
    endfunction

    logic [1:0]        cmd_reg, cmd_next;
    logic [3:0]        res_reg, res_next;
    logic [3:0]        pid_reg, pid_next;
    logic [RW-1:0]     r_reg, r_next;
    logic [4:0]        i_reg, i_next;
    logic [4:0]        k_reg, k_next;
    logic [3:0]        h_reg, h_next;
    logic [3:0]        woke_reg, woke_next;
    logic [3:0]        w_reg, w_next;
    logic [3:0]        rescnt_reg, rescnt_next;
    logic signed [8:0] cnt_reg [NUM_RESOURCES];
    logic signed [8:0] cnt_next [NUM_RESOURCES];
    logic [4:0]        len_reg [NUM_RESOURCES];
    logic [4:0]        len_next [NUM_RESOURCES];
    logic [3:0]        head_reg [NUM_RESOURCES];
    logic [3:0]        head_next [NUM_RESOURCES];
    logic [DEPTH-1:0]  vld_reg, vld_next;
    logic              vldq_reg;
    logic              out_valid_reg, out_valid_next;
    rsp_t              out_reg, out_next;

    logic          q_we, q_re, h_we, h_re;
    logic [AW-1:0] q_waddr, q_raddr, h_waddr, h_raddr;
    logic [3:0]    q_wdata, q_rdata, h_wdata, h_rdata;

    logic              res_in_range;
    logic [3:0]        active;
    logic [RW-1:0]     rsel;
    logic signed [8:0] cur_cnt, credit_val, dec_val;
    logic [4:0]        cur_len;
    logic [3:0]        cur_head;
    logic [3:0]        held_q;
    logic              wait_neg;
    logic              r_last;
    logic [RW-1:0]     r_inc;

    csm_ram #(.WIDTH(4), .DEPTH(DEPTH)) u_queue_ram (
        .clk   (clk),
        .we    (q_we),
        .waddr (q_waddr),
        .wdata (q_wdata),
        .re    (q_re),
        .raddr (q_raddr),
        .rdata (q_rdata)
    );

    csm_ram #(.WIDTH(4), .DEPTH(DEPTH)) u_held_ram (
        .clk   (clk),
        .we    (h_we),
        .waddr (h_waddr),
        .wdata (h_wdata),
        .re    (h_re),
        .raddr (h_raddr),
        .rdata (h_rdata)
    );

    assign res_in_range = (32'(res_reg) < NUM_RESOURCES);
    assign active       = (32'(rescnt_reg) > NUM_RESOURCES) ? 4'(NUM_RESOURCES) : rescnt_reg;
    assign rsel         = res_in_range ? res_reg[RW-1:0] : '0;
    assign cur_cnt      = cnt_reg[r_reg];
    assign cur_len      = len_reg[r_reg];
    assign cur_head     = head_reg[r_reg];
    assign credit_val   = (cur_cnt < COUNT_MAX) ? cur_cnt + 9'sd1 : cur_cnt;
    assign dec_val      = (cur_cnt > COUNT_MIN) ? cur_cnt - 9'sd1 : cur_cnt;
    assign wait_neg     = (dec_val < 9'sd0);
    assign held_q       = vldq_reg ? h_rdata : 4'd0;
    assign r_last       = (32'(r_reg) == NUM_RESOURCES - 1);
    assign r_inc        = r_last ? '0 : r_reg + RW'(1);

    always_comb
    begin
        stat.cmd       = cmd_reg;
        stat.pid_bad   = (32'(pid_reg) >= MAX_PROCESSES);
        stat.res_bad   = (res_reg >= active);
        stat.wait_neg  = wait_neg;
        stat.q_full    = cur_len[4];
        stat.len_nz    = (cur_len != 5'd0);
        stat.i_lt_len  = (i_reg < cur_len);
        stat.r_last    = r_last;
        stat.h_nz      = (h_reg != 4'd0);
        stat.woke_full = (woke_reg == WAKE_REPORT_MAX);
    end

    always_comb
    begin
        cmd_next    = cmd_reg;
        res_next    = res_reg;
        pid_next    = pid_reg;
        r_next      = r_reg;
        i_next      = i_reg;
        k_next      = k_reg;
        h_next      = h_reg;
        woke_next   = woke_reg;
        w_next      = w_reg;
        rescnt_next = rescnt_reg;
        cnt_next    = cnt_reg;
        len_next    = len_reg;
        head_next   = head_reg;
        vld_next    = vld_reg;
        q_we = 1'b0; q_waddr = '0; q_wdata = 4'd0;
        q_re = 1'b0; q_raddr = '0;
        h_we = 1'b0; h_waddr = '0; h_wdata = 4'd0;
        h_re = 1'b0; h_raddr = '0;

        case (ctl.op)
            OP_LATCH:
            begin
                cmd_next  = request.cmd;
                res_next  = request.resource_index;
                pid_next  = request.process_id;
                woke_next = 4'd0;
            end
            OP_LOOKUP:
            begin
                r_next  = (cmd_reg == CMD_RELEASE) ? '0 : rsel;
                i_next  = 5'd0;
                k_next  = 5'd0;
                q_re    = 1'b1;
                q_raddr = mk_addr(rsel, head_reg[rsel]);
                h_re    = 1'b1;
                h_raddr = mk_addr(rsel, pid_reg);
            end
            OP_WAIT:
            begin
                if (wait_neg)
                begin
                    if (!cur_len[4])
                    begin
                        cnt_next[r_reg] = dec_val;
                        q_we            = 1'b1;
                        q_waddr         = mk_addr(r_reg, cur_head + cur_len[3:0]);
                        q_wdata         = pid_reg;
                        len_next[r_reg] = cur_len + 5'd1;
                    end
                end
                else
                begin
                    cnt_next[r_reg] = dec_val;
                    h_we            = 1'b1;
                    h_waddr         = mk_addr(r_reg, pid_reg);
                    h_wdata         = (held_q == HELD_MAX) ? HELD_MAX : held_q + 4'd1;
                end
            end
            OP_SIG:
            begin
                cnt_next[r_reg] = credit_val;
                if (held_q != 4'd0)
                begin
                    h_we    = 1'b1;
                    h_waddr = mk_addr(r_reg, pid_reg);
                    h_wdata = held_q - 4'd1;
                end
                if (cur_len != 5'd0)
                begin
                    head_next[r_reg] = cur_head + 4'd1;
                    len_next[r_reg]  = cur_len - 5'd1;
                    w_next           = q_rdata;
                end
            end
            OP_RQ:
            begin
                if (i_reg < cur_len)
                begin
                    q_re    = 1'b1;
                    q_raddr = mk_addr(r_reg, cur_head + i_reg[3:0]);
                end
                else
                begin
                    len_next[r_reg] = k_reg;
                    r_next          = r_inc;
                    i_next          = 5'd0;
                    k_next          = 5'd0;
                end
            end
            OP_RQ_CHK:
            begin
                if (q_rdata == pid_reg)
                begin
                    cnt_next[r_reg] = credit_val;
                end
                else
                begin
                    q_we    = 1'b1;
                    q_waddr = mk_addr(r_reg, cur_head + k_reg[3:0]);
                    q_wdata = q_rdata;
                    k_next  = k_reg + 5'd1;
                end
                i_next = i_reg + 5'd1;
            end
            OP_RH_RD:
            begin
                h_re    = 1'b1;
                h_raddr = mk_addr(r_reg, pid_reg);
            end
            OP_RH_LOAD:
            begin
                h_next = held_q;
            end
            OP_RW:
            begin
                if (h_reg != 4'd0)
                begin
                    cnt_next[r_reg] = credit_val;
                    h_next          = h_reg - 4'd1;
                    if (cur_len != 5'd0)
                    begin
                        q_re    = 1'b1;
                        q_raddr = mk_addr(r_reg, cur_head);
                    end
                end
                else
                begin
                    h_we    = 1'b1;
                    h_waddr = mk_addr(r_reg, pid_reg);
                    h_wdata = 4'd0;
                    r_next  = r_inc;
                end
            end
            OP_POP:
            begin
                head_next[r_reg] = cur_head + 4'd1;
                len_next[r_reg]  = cur_len - 5'd1;
                w_next           = q_rdata;
            end
            OP_RD_HW:
            begin
                h_re    = 1'b1;
                h_raddr = mk_addr(r_reg, w_reg);
            end
            OP_WAKE:
            begin
                h_we    = 1'b1;
                h_waddr = mk_addr(r_reg, w_reg);
                h_wdata = (held_q == HELD_MAX) ? HELD_MAX : held_q + 4'd1;
                if (woke_reg != WAKE_REPORT_MAX)
                begin
                    woke_next = woke_reg + 4'd1;
                end
            end
            default:
            begin
            end
        endcase

        if (h_we)
        begin
            vld_next[h_waddr] = 1'b1;
        end

        if (cfg_valid)
        begin
            if (cfg_index == CFG_RESOURCE_COUNT)
            begin
                rescnt_next = cfg_data[3:0];
            end
            else
            begin
                for (int r = 0; r < NUM_RESOURCES; r++)
                begin
                    cnt_next[r] = {1'b0, cfg_data[8*r +: 8]};
                end
            end
        end
    end

    always_comb
    begin
        out_valid_next = ctl.ev_valid;
        out_next       = out_reg;
        if (ctl.ev_valid)
        begin
            out_next.event_res     = ctl.ev_code;
            out_next.event_process = (ctl.ev_code == EV_WOKEN) ? w_reg : pid_reg;
            if (ctl.ev_code == EV_RELEASE_DONE)
            begin
                out_next.event_resource = 4'd0;
            end
            else if (ctl.ev_code == EV_INVALID)
            begin
                out_next.event_resource = res_reg;
            end
            else
            begin
                out_next.event_resource = 4'(r_reg);
            end
            out_next.last = ctl.ev_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_reg       <= CMD_WAIT;
            res_reg       <= 4'd0;
            pid_reg       <= 4'd0;
            r_reg         <= '0;
            i_reg         <= 5'd0;
            k_reg         <= 5'd0;
            h_reg         <= 4'd0;
            woke_reg      <= 4'd0;
            w_reg         <= 4'd0;
            rescnt_reg    <= 4'd1;
            vld_reg       <= '0;
            vldq_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            out_reg       <= '0;
            for (int r = 0; r < NUM_RESOURCES; r++)
            begin
                cnt_reg[r]  <= 9'sd0;
                len_reg[r]  <= 5'd0;
                head_reg[r] <= 4'd0;
            end
        end
        else
        begin
            cmd_reg       <= cmd_next;
            res_reg       <= res_next;
            pid_reg       <= pid_next;
            r_reg         <= r_next;
            i_reg         <= i_next;
            k_reg         <= k_next;
            h_reg         <= h_next;
            woke_reg      <= woke_next;
            w_reg         <= w_next;
            rescnt_reg    <= rescnt_next;
            vld_reg       <= vld_next;
            out_valid_reg <= out_valid_next;
            out_reg       <= out_next;
            if (h_re)
            begin
                vldq_reg <= vld_reg[h_raddr];
            end
            cnt_reg  <= cnt_next;
            len_reg  <= len_next;
            head_reg <= head_next;
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    `CSM_NEVER(a_held_rw_clash, h_we && h_re && (h_waddr == h_raddr), "held read meets write")
    `CSM_NEVER(a_queue_rw_clash, q_we && q_re && (q_waddr == q_raddr), "queue read meets write")
    `CSM_NEVER(a_queue_overflow, q_we && (ctl.op == OP_WAIT) && cur_len[4], "push to full queue")

endmodule

>>> src/counting_semaphore_manager.sv
// Wait: checked, then answered as granted, blocked or invalid. Signal: credits the count,
// wakes the first waiter if any, then reports done. Release: purges the process from every
// queue, crediting each removed entry, then returns each held instance, waking one waiter
// per instance, and reports done. One command is in flight at a time.
// Reset: counts zero, queues empty, holdings zero, resource count one.
// Results are strobed for one cycle and are never stalled by the receiver.
module counting_semaphore_manager import csm_pkg::*; #(
    parameter int NUM_RESOURCES = DEF_NUM_RESOURCES,
    parameter int MAX_PROCESSES = DEF_MAX_PROCESSES
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  req_t        request,
    output logic        result_valid,
    output rsp_t        result,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [63:0] cfg_data
);

    dp_cmd_t  ctl;
    dp_stat_t stat;

    assign cfg_ready = 1'b1;

    csm_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .stat  (stat),
        .ctl   (ctl)
    );

    csm_dp #(
        .NUM_RESOURCES (NUM_RESOURCES),
        .MAX_PROCESSES (MAX_PROCESSES)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .request      (request),
        .ctl          (ctl),
        .stat         (stat),
        .result_valid (result_valid),
        .result       (result)
    );

endmodule

>>> verif/tb_counting_semaphore_manager.sv
// Self-checking testbench for the counting semaphore unit (counting_semaphore_manager).
// Depends on csm_pkg for the request, response and code definitions, and on the RTL only.
// A directed table runs first, then random phases under several register settings.
`timescale 1ns / 1ps

module tb_counting_semaphore_manager;
    import csm_pkg::*;

    localparam int N_RES      = 8;
    localparam int N_PROC     = 16;
    localparam int CYCLE_LIMIT = 5000000;

    typedef struct {
        req_t req;
        bit   typed;
        rsp_t ev;
    } table_row_t;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    req_t        request;
    logic        result_valid;
    rsp_t        result;
    logic        cfg_valid;
    logic        cfg_ready;
    logic        cfg_index;
    logic [63:0] cfg_data;

    logic signed [8:0] sem_count [N_RES];
    logic [3:0]        waiters   [N_RES][QUEUE_DEPTH];
    int                waiter_len [N_RES];
    logic [3:0]        held      [N_RES][N_PROC];
    logic [3:0]        res_limit;
    logic [63:0]       start_counts;

    rsp_t        predicted_events [$];
    rsp_t        expected_events [$];
    int          errors;
    int          cycles;
    bit          no_idle;
    table_row_t  directed [20];

    counting_semaphore_manager uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .request      (request),
        .result_valid (result_valid),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles", cycles);
            $display("Some tests failed");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("Mismatch %s: got %0d, expected %0d", what, got, want);
        errors++;
    endtask

    always @(negedge clk)
    begin
        rsp_t want;
        if (rst_n && result_valid)
        begin
            if (expected_events.size() == 0)
            begin
                report_mismatch("unexpected event_res", result.event_res, -1);
            end
            else
            begin
                want = expected_events.pop_front();
                if (result.event_res !== want.event_res)
                    report_mismatch("event_res", result.event_res, want.event_res);
                if (result.event_process !== want.event_process)
                    report_mismatch("event_process", result.event_process, want.event_process);
                if (result.event_resource !== want.event_resource)
                    report_mismatch("event_resource", result.event_resource,
                                    want.event_resource);
                if (result.last !== want.last)
                    report_mismatch("last", result.last, want.last);
            end
        end
    end

    function automatic void load_start_counts();
        for (int r = 0; r < N_RES; r++)
            sem_count[r] = {1'b0, start_counts[8*r +: 8]};
    endfunction

    function automatic void push_event(logic [2:0] code, logic [3:0] pid, logic [3:0] res);
        rsp_t ev;
        ev.event_res      = code;
        ev.event_process  = pid;
        ev.event_resource = res;
        ev.last           = 1'b0;
        predicted_events.push_back(ev);
    endfunction

    function automatic void credit_count(int r);
        if (sem_count[r] < COUNT_MAX)
            sem_count[r] = sem_count[r] + 9'sd1;
    endfunction

    function automatic void wake_first_waiter(int r);
        logic [3:0] w;
        if (waiter_len[r] == 0)
            return;
        w = waiters[r][0];
        for (int i = 1; i < waiter_len[r]; i++)
            waiters[r][i-1] = waiters[r][i];
        waiter_len[r]--;
        if (held[r][w] < HELD_MAX)
            held[r][w]++;
        if (predicted_events.size() < WAKE_REPORT_MAX)
            push_event(EV_WOKEN, w, r[3:0]);
    endfunction

    // Works out the events one accepted command causes and updates the shadow state.
    function automatic void predict_events(req_t rq);
        int active;
        int k;
        int res;
        logic signed [8:0] next;
        rsp_t tail;
        predicted_events.delete();
        active = (res_limit > N_RES) ? N_RES : res_limit;
        res = rq.resource_index;
        if (rq.cmd == CMD_UNUSED)
            return;
        if (rq.cmd == CMD_RELEASE)
        begin
            for (int r = 0; r < N_RES; r++)
            begin
                k = 0;
                for (int i = 0; i < waiter_len[r]; i++)
                begin
                    if (waiters[r][i] == rq.process_id)
                        credit_count(r);
                    else
                    begin
                        waiters[r][k] = waiters[r][i];
                        k++;
                    end
                end
                waiter_len[r] = k;
            end
            for (int r = 0; r < N_RES; r++)
            begin
                for (int i = 0; i < held[r][rq.process_id]; i++)
                begin
                    credit_count(r);
                    wake_first_waiter(r);
                end
                held[r][rq.process_id] = 4'd0;
            end
            push_event(EV_RELEASE_DONE, rq.process_id, 4'd0);
        end
        else if (res >= active)
            push_event(EV_INVALID, rq.process_id, rq.resource_index);
        else if (rq.cmd == CMD_WAIT)
        begin
            next = (sem_count[res] > COUNT_MIN) ? sem_count[res] - 9'sd1 : COUNT_MIN;
            if (next < 0)
            begin
                if (waiter_len[res] >= QUEUE_DEPTH)
                    push_event(EV_INVALID, rq.process_id, rq.resource_index);
                else
                begin
                    sem_count[res] = next;
                    waiters[res][waiter_len[res]] = rq.process_id;
                    waiter_len[res]++;
                    push_event(EV_BLOCKED, rq.process_id, rq.resource_index);
                end
            end
            else
            begin
                sem_count[res] = next;
                if (held[res][rq.process_id] < HELD_MAX)
                    held[res][rq.process_id]++;
                push_event(EV_GRANTED, rq.process_id, rq.resource_index);
            end
        end
        else
        begin
            credit_count(res);
            if (held[res][rq.process_id] > 0)
                held[res][rq.process_id]--;
            wake_first_waiter(res);
            push_event(EV_SIGNAL_DONE, rq.process_id, rq.resource_index);
        end
        tail = predicted_events.pop_back();
        tail.last = 1'b1;
        predicted_events.push_back(tail);
    endfunction

    task automatic wait_until_idle();
        while (expected_events.size() != 0)
            @(posedge clk);
        repeat (600) @(posedge clk);
        start <= 1'b0;
        @(negedge clk);
        while (busy)
            @(negedge clk);
        @(posedge clk);
    endtask

    task automatic write_register(input logic idx, input logic [63:0] value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        forever
        begin
            @(negedge clk);
            if (cfg_ready)
            begin
                @(posedge clk);
                break;
            end
            @(posedge clk);
        end
        cfg_valid <= 1'b0;
        if (idx == CFG_RESOURCE_COUNT)
            res_limit = value[3:0];
        else
        begin
            start_counts = value;
            load_start_counts();
        end
    endtask

    task automatic issue_command(input req_t rq, input bit typed, input rsp_t typed_ev);
        int gap;
        gap = (!no_idle && $urandom_range(99) < 30) ? $urandom_range(1, 6) : 0;
        repeat (gap + 1) @(posedge clk);
        start   <= 1'b1;
        request <= rq;
        forever
        begin
            @(negedge clk);
            if (!busy)
            begin
                @(posedge clk);
                break;
            end
            @(posedge clk);
        end
        start <= 1'b0;
        predict_events(rq);
        if (typed)
            expected_events.push_back(typed_ev);
        else
            foreach (predicted_events[i])
                expected_events.push_back(predicted_events[i]);
    endtask

    function automatic table_row_t row(logic [1:0] cmd, int res, int pid, bit typed,
                                       logic [2:0] code, int ev_pid, int ev_res);
        table_row_t t;
        t.req.cmd            = cmd;
        t.req.resource_index = res[3:0];
        t.req.process_id     = pid[3:0];
        t.typed              = typed;
        t.ev.event_res       = code;
        t.ev.event_process   = ev_pid[3:0];
        t.ev.event_resource  = ev_res[3:0];
        t.ev.last            = 1'b1;
        return t;
    endfunction

    function automatic req_t random_request(int pid_span, int res_span);
        req_t rq;
        int pick;
        pick = $urandom_range(99);
        if (pick < 42)
            rq.cmd = CMD_WAIT;
        else if (pick < 80)
            rq.cmd = CMD_SIGNAL;
        else if (pick < 95)
            rq.cmd = CMD_RELEASE;
        else
            rq.cmd = CMD_UNUSED;
        rq.resource_index = ($urandom_range(99) < 8) ? $urandom_range(15)
                                                     : $urandom_range(res_span - 1);
        rq.process_id = $urandom_range(pid_span - 1);
        return rq;
    endfunction

    initial
    begin
        logic [63:0] counts;
        logic [3:0]  limit;
        int pid_span;
        rsp_t none;

        none      = '0;
        errors    = 0;
        cycles    = 0;
        no_idle   = 1'b0;
        rst_n     = 1'b0;
        start     = 1'b0;
        request   = '0;
        cfg_valid = 1'b0;
        cfg_index = CFG_RESOURCE_COUNT;
        cfg_data  = '0;

        res_limit    = 4'd1;
        start_counts = '0;
        load_start_counts();
        for (int r = 0; r < N_RES; r++)
        begin
            waiter_len[r] = 0;
            for (int p = 0; p < N_PROC; p++)
                held[r][p] = 4'd0;
        end

        directed[0]  = row(CMD_WAIT,    0,  1, 1, EV_BLOCKED,  1,  0);
        directed[1]  = row(CMD_WAIT,    5,  2, 1, EV_INVALID,  2,  5);
        directed[2]  = row(CMD_WAIT,   15, 15, 1, EV_INVALID, 15, 15);
        directed[3]  = row(CMD_UNUSED,  0,  0, 0, EV_GRANTED,  0,  0);
        directed[4]  = row(CMD_WAIT,    0,  0, 1, EV_BLOCKED,  0,  0);
        directed[5]  = row(CMD_SIGNAL,  0,  3, 0, EV_GRANTED,  0,  0);
        directed[6]  = row(CMD_RELEASE, 9,  0, 0, EV_GRANTED,  0,  0);
        directed[7]  = row(CMD_SIGNAL,  0, 15, 0, EV_GRANTED,  0,  0);
        directed[8]  = row(CMD_WAIT,    7,  4, 1, EV_BLOCKED,  4,  7);
        directed[9]  = row(CMD_SIGNAL,  1,  5, 1, EV_SIGNAL_DONE, 5, 1);
        directed[10] = row(CMD_WAIT,    1,  6, 1, EV_GRANTED,  6,  1);
        directed[11] = row(CMD_WAIT,    8,  0, 1, EV_INVALID,  0,  8);
        directed[12] = row(CMD_RELEASE, 0,  4, 0, EV_GRANTED,  0,  0);
        directed[13] = row(CMD_RELEASE, 3,  6, 0, EV_GRANTED,  0,  0);
        directed[14] = row(CMD_WAIT,    2,  9, 1, EV_BLOCKED,  9,  2);
        directed[15] = row(CMD_WAIT,    2, 10, 1, EV_BLOCKED, 10,  2);
        directed[16] = row(CMD_SIGNAL,  2,  9, 0, EV_GRANTED,  0,  0);
        directed[17] = row(CMD_RELEASE, 2, 10, 0, EV_GRANTED,  0,  0);
        directed[18] = row(CMD_UNUSED, 15, 15, 0, EV_GRANTED,  0,  0);
        directed[19] = row(CMD_WAIT,    4, 15, 1, EV_GRANTED, 15,  4);

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed[i])
        begin
            if (i == 8)
            begin
                wait_until_idle();
                write_register(CFG_RESOURCE_COUNT, 64'd8);
                write_register(CFG_INITIAL_INSTANCES, 64'h00_01_FF_FE_02_00_FF_01);
            end
            issue_command(directed[i].req, directed[i].typed, directed[i].ev);
        end

        for (int ph = 0; ph < 8; ph++)
        begin
            wait_until_idle();
            case (ph)
                0: begin limit = 4'd1;  counts = '1; end
                1: begin limit = 4'd8;  counts = '0; end
                2: begin limit = 4'd15; counts = {$urandom, $urandom}; end
                default:
                begin
                    limit = $urandom_range(1, 8);
                    counts = '0;
                    for (int r = 0; r < N_RES; r++)
                        counts[8*r +: 8] = $urandom_range(3);
                end
            endcase
            write_register(CFG_RESOURCE_COUNT, {60'd0, limit});
            write_register(CFG_INITIAL_INSTANCES, counts);
            no_idle  = (ph == 3);
            pid_span = (ph == 0 || ph == 5) ? 2 : ((ph % 2) ? 16 : 5);
            for (int n = 0; n < 56; n++)
            begin
                if (ph == 4 && n == 28)
                begin
                    while (expected_events.size() != 0)
                        @(posedge clk);
                end
                issue_command(random_request(pid_span, (limit > N_RES) ? N_RES + 1 : limit + 1),
                              1'b0, none);
            end
        end

        while (expected_events.size() != 0)
            @(posedge clk);
        repeat (600) @(posedge clk);
        if (errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

>>> sim.f
+incdir+src
src/csm_pkg.sv
src/csm_ram.sv
src/csm_ctrl.sv
src/csm_dp.sv
src/counting_semaphore_manager.sv
verif/tb_counting_semaphore_manager.sv
